>>> sv/srf_pkg.sv
// ----------------------------------------------------------------------------
// srf_pkg - shared constants for the Schroeder reverb filter
// Widths, defaults, register indexes and the fixed all-pass gain.
// ----------------------------------------------------------------------------
package srf_pkg;

   localparam int COMB_DEPTH_DEF    = 4096;
   localparam int ALLPASS_DELAY_DEF = 1968;
   localparam int SAMPLE_WIDTH_DEF  = 16;

   localparam int INT_W   = 24;
   localparam int CFG_W   = 15;
   localparam int CIDX_W  = 3;
   localparam int DELAY_W = 12;
   localparam int GAIN_W  = 15;
   localparam int WET_W   = 7;

   localparam logic [GAIN_W-1:0] ALLPASS_GAIN = 15'd4293;

   localparam logic [CIDX_W-1:0] REG_DELAY_1  = 3'd0;
   localparam logic [CIDX_W-1:0] REG_DELAY_2  = 3'd1;
   localparam logic [CIDX_W-1:0] REG_DELAY_3  = 3'd2;
   localparam logic [CIDX_W-1:0] REG_DELAY_4  = 3'd3;
   localparam logic [CIDX_W-1:0] REG_FEEDBACK = 3'd4;
   localparam logic [CIDX_W-1:0] REG_WET      = 3'd5;

   // round-to-nearest Q15 scale, ties toward plus infinity
   function automatic logic signed [INT_W+1:0] round_q15(input logic signed [INT_W+16:0] p);
      logic signed [INT_W+16:0] t;
      begin
         t = p + 41'sd16384;
         round_q15 = t[INT_W+16:15];
      end
   endfunction

   // saturate a 27-bit value to 24 bits
   function automatic logic [INT_W:0] sat24(input logic signed [INT_W+2:0] v);
      begin
         if (v > 27'sd8388607)
            sat24 = {1'b1, 24'h7FFFFF};
         else if (v < -27'sd8388608)
            sat24 = {1'b1, 24'h800000};
         else
            sat24 = {1'b0, v[INT_W-1:0]};
      end
   endfunction

endpackage

>>> sv/srf_mul.sv
// ----------------------------------------------------------------------------
// srf_mul - shared Q15 gain multiplier
// One registered 15x24 product with round-to-nearest scaling.
// ----------------------------------------------------------------------------
module srf_mul (
   input  logic                                  clock,
   input  logic [srf_pkg::GAIN_W-1:0]            gain,
   input  logic signed [srf_pkg::INT_W-1:0]      value,
   output logic signed [srf_pkg::INT_W+1:0]      prod
);
   logic signed [srf_pkg::INT_W+16:0] p_ff;
   logic signed [srf_pkg::INT_W+16:0] p_in;

   assign p_in = $signed({1'b0, gain}) * value;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign prod = srf_pkg::round_q15(p_ff);
endmodule

>>> sv/schroeder_reverb_filter_top.sv
// ----------------------------------------------------------------------------
// schroeder_reverb_filter_top - streaming Schroeder reverberator
// Four feedback combs, a wet/dry blend and two all-pass stages.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one signed sample in req_tdata; rsp_ returns one result per
//   sample: tdata = sample_out, tuser = clipped.
//   csr_ writes a register by index (delays 0..3, feedback 4, wet 5); write
//   only while the block is idle, which the block itself does not enforce.
//   Each sample is worked by a sequencer that runs the four comb lines and
//   two all-pass lines through one multiplier and one read port per memory,
//   one step a cycle, but the last step holds while the output register is
//   full. A new sample is taken only once the sequencer is back in idle.
//   The result sits in an output register; the next sample is accepted as
//   soon as the sequencer is free, even while that result is stalled, but a
//   new result waits until the previous one has been taken.
//   After reset the block runs a clearing pass that writes zeros over the
//   delay memories before accepting the first sample.
// ----------------------------------------------------------------------------
module schroeder_reverb_filter_top #(
   parameter int ALLPASS_DELAY = srf_pkg::ALLPASS_DELAY_DEF,
   parameter int SAMPLE_WIDTH  = srf_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] req_tdata,  // sample_in
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] rsp_tdata,  // sample_out
   output logic                              rsp_tuser,  // clipped
   input  logic                              csr_we,
   input  logic [srf_pkg::CIDX_W-1:0]        csr_index,
   input  logic [srf_pkg::CFG_W-1:0]         csr_wdata
);
   localparam int COMB_DEPTH = srf_pkg::COMB_DEPTH_DEF;
   localparam int IW   = srf_pkg::INT_W;
   localparam int CAW  = $clog2(COMB_DEPTH);
   localparam int AAW  = $clog2(ALLPASS_DELAY);
   localparam int TDW  = ((SAMPLE_WIDTH+7)/8)*8;
   localparam int CLR_LEN = (4*COMB_DEPTH > 2*ALLPASS_DELAY) ? 4*COMB_DEPTH
                                                             : 2*ALLPASS_DELAY;
   localparam int CLW  = $clog2(CLR_LEN+1);

   localparam logic [4:0] ST_CLEAR   = 5'd0;
   localparam logic [4:0] ST_IDLE    = 5'd1;
   localparam logic [4:0] ST_CRD_0   = 5'd2;   // first comb read
   localparam logic [4:0] ST_CRD_3   = 5'd5;   // last comb read
   localparam logic [4:0] ST_CWR_0   = 5'd4;   // first comb write back
   localparam logic [4:0] ST_CWR_3   = 5'd7;   // last comb write back
   localparam logic [4:0] ST_BLEND   = 5'd8;
   localparam logic [4:0] ST_RECIP   = 5'd9;
   localparam logic [4:0] ST_DIV     = 5'd10;
   localparam logic [4:0] ST_AP1_RD  = 5'd11;
   localparam logic [4:0] ST_AP1_W   = 5'd12;
   localparam logic [4:0] ST_AP1_MUL = 5'd13;
   localparam logic [4:0] ST_AP1_Y   = 5'd14;
   localparam logic [4:0] ST_AP2_RD  = 5'd15;
   localparam logic [4:0] ST_AP2_W   = 5'd16;
   localparam logic [4:0] ST_AP2_MUL = 5'd17;
   localparam logic [4:0] ST_AP2_Y   = 5'd18;
   localparam logic [4:0] ST_AP_ADV  = 5'd19;
   localparam logic [4:0] ST_DONE    = 5'd20;

   // configuration
   logic [11:0] dly_ff [4];
   logic [14:0] fb_ff;
   logic [6:0]  wet_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dly_ff[0] <= 12'd1102;
         dly_ff[1] <= 12'd843;
         dly_ff[2] <= 12'd1528;
         dly_ff[3] <= 12'd926;
         fb_ff     <= 15'd16384;
         wet_ff    <= 7'd50;
      end else if (csr_we) begin
         case (csr_index)
            srf_pkg::REG_DELAY_1:  dly_ff[0] <= csr_wdata[11:0];
            srf_pkg::REG_DELAY_2:  dly_ff[1] <= csr_wdata[11:0];
            srf_pkg::REG_DELAY_3:  dly_ff[2] <= csr_wdata[11:0];
            srf_pkg::REG_DELAY_4:  dly_ff[3] <= csr_wdata[11:0];
            srf_pkg::REG_FEEDBACK: fb_ff     <= csr_wdata;
            srf_pkg::REG_WET:      wet_ff    <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // memories: one comb memory with four banks by address, one all-pass memory
   logic [IW-1:0] comb_mem [4*COMB_DEPTH];
   logic [IW-1:0] ap_mem   [2*ALLPASS_DELAY];
   logic [CAW+1:0] comb_raddr, comb_waddr;
   logic [AAW:0]   ap_raddr, ap_waddr;
   logic           comb_we, ap_we;
   logic [IW-1:0]  comb_wdata, ap_wdata;
   logic [IW-1:0]  comb_rd_ff, ap_rd_ff;

   always_ff @(posedge clock) begin
      if (comb_we) comb_mem[comb_waddr] <= comb_wdata;
      comb_rd_ff <= comb_mem[comb_raddr];
   end
   always_ff @(posedge clock) begin
      if (ap_we) ap_mem[ap_waddr] <= ap_wdata;
      ap_rd_ff <= ap_mem[ap_raddr];
   end

   // sequencer
   logic [4:0]     st_ff, st_in;
   logic [CLW-1:0] clr_ff, clr_in;
   logic [CAW-1:0] cwp_ff, cwp_in;
   logic [AAW-1:0] awp_ff, awp_in;
   logic signed [SAMPLE_WIDTH-1:0] x_ff, x_in;
   logic signed [IW+8:0] acc_ff, acc_in;   // comb sum, later blend numerator
   logic signed [IW+8:0] quo_ff, quo_in;   // quotient estimate of the blend
   logic signed [IW-1:0] v_ff, v_in;       // current stage value
   logic signed [IW-1:0] old_ff, old_in;   // all-pass delayed value
   logic           sat_ff, sat_in;
   logic           ov_ff, ov_in;
   logic [SAMPLE_WIDTH-1:0] out_ff, out_in;
   logic           oflag_ff, oflag_in;

   logic [14:0]    mgain;
   logic signed [IW-1:0] mval;
   logic signed [IW+1:0] mprod;

   srf_mul u_mul (.clock(clock), .gain(mgain), .value(mval), .prod(mprod));

   logic signed [IW:0]   xe;
   logic [IW:0]          s1;
   logic [1:0]           cidx;
   logic [CAW-1:0]       rdp;
   logic [6:0]           wet;
   logic signed [IW+8:0] num;
   logic signed [IW+8:0] q;
   logic signed [IW+40:0] qm;
   logic signed [IW+8:0] rem;
   logic [IW:0]          sq;
   logic signed [IW+2:0] tmp;
   logic [IW:0]          sv;

   assign xe  = (IW+1)'(x_ff);
   assign wet = (wet_ff > 7'd100) ? 7'd100 : wet_ff;
   assign req_tready = (st_ff == ST_IDLE);

   always_comb begin
      st_in    = st_ff;
      clr_in   = clr_ff;
      cwp_in   = cwp_ff;
      awp_in   = awp_ff;
      x_in     = x_ff;
      acc_in   = acc_ff;
      quo_in   = quo_ff;
      v_in     = v_ff;
      old_in   = old_ff;
      sat_in   = sat_ff;
      ov_in    = ov_ff;
      out_in   = out_ff;
      oflag_in = oflag_ff;
      comb_we  = 1'b0;
      ap_we    = 1'b0;
      comb_waddr = '0;
      comb_wdata = '0;
      ap_waddr   = '0;
      ap_wdata   = '0;
      comb_raddr = '0;
      ap_raddr   = '0;
      mgain = fb_ff;
      mval  = comb_rd_ff;
      cidx  = '0;
      rdp   = '0;
      num   = '0;
      q     = '0;
      qm    = '0;
      rem   = '0;
      sq    = '0;
      tmp   = '0;
      sv    = '0;
      s1    = '0;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (st_ff)
         ST_CLEAR: begin
            // sweep both memories with zeros
            comb_we    = clr_ff < CLW'(4*COMB_DEPTH);
            comb_waddr = clr_ff[CAW+1:0];
            ap_we      = clr_ff < CLW'(2*ALLPASS_DELAY);
            ap_waddr   = clr_ff[AAW:0];
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == CLW'(CLR_LEN-1))
               st_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               x_in   = req_tdata[SAMPLE_WIDTH-1:0];
               acc_in = '0;
               sat_in = 1'b0;
               st_in  = ST_CRD_0;
            end
         end
         default: begin
            // comb reads reach their write back via the read and product registers
            if (st_ff inside {[ST_CRD_0:ST_CRD_3]}) begin
               cidx = 2'(st_ff - ST_CRD_0);
               rdp  = cwp_ff - CAW'(dly_ff[cidx]);
               comb_raddr = {cidx, rdp};
            end
            if (st_ff inside {[ST_CWR_0:ST_CWR_3]}) begin
               cidx = 2'(st_ff - ST_CWR_0);
               tmp  = (IW+3)'(xe) + (IW+3)'(mprod);
               s1   = srf_pkg::sat24(tmp);
               comb_we    = 1'b1;
               comb_waddr = {cidx, cwp_ff};
               comb_wdata = s1[IW-1:0];
               acc_in = acc_ff + (IW+9)'($signed(s1[IW-1:0]));
               sat_in = sat_ff | s1[IW];
            end
            if (st_ff == ST_BLEND) begin
               cwp_in = cwp_ff + 1'b1;
               num = $signed({1'b0, 7'd100 - wet}) * (IW+9)'(x_ff)
                   + $signed({1'b0, wet}) * acc_ff + (IW+9)'(50);
               acc_in = num;
            end
            if (st_ff == ST_RECIP) begin
               // reciprocal estimate of the divide by 100, may be one off
               qm     = acc_ff * $signed(33'sd1374389535);
               quo_in = (IW+9)'(qm >>> 37);
            end
            if (st_ff == ST_DIV) begin
               // correct the estimate to a floor quotient, then saturate
               q   = quo_ff;
               rem = acc_ff - q * (IW+9)'(100);
               if (rem < 0) q = q - 1'b1;
               else if (rem >= (IW+9)'(100)) q = q + 1'b1;
               sq   = srf_pkg::sat24((IW+3)'(q));
               v_in = sq[IW-1:0];
               sat_in = sat_ff | sq[IW];
               ap_raddr = {1'b0, awp_ff};
            end
            if (st_ff == ST_AP1_RD || st_ff == ST_AP2_RD) begin
               old_in = ap_rd_ff;
               mgain  = srf_pkg::ALLPASS_GAIN;
               mval   = ap_rd_ff;
            end
            if (st_ff == ST_AP1_W || st_ff == ST_AP2_W) begin
               tmp  = (IW+3)'(v_ff) + (IW+3)'(mprod);
               sv   = srf_pkg::sat24(tmp);
               v_in = sv[IW-1:0];
               sat_in = sat_ff | sv[IW];
               ap_we  = 1'b1;
               ap_waddr = (st_ff == ST_AP1_W) ? {1'b0, awp_ff}
                                          : (AAW+1)'(awp_ff) + (AAW+1)'(ALLPASS_DELAY);
               ap_wdata = sv[IW-1:0];
            end
            if (st_ff == ST_AP1_MUL || st_ff == ST_AP2_MUL) begin
               mgain = srf_pkg::ALLPASS_GAIN;
               mval  = v_ff;
            end
            if (st_ff == ST_AP1_Y || st_ff == ST_AP2_Y) begin
               tmp  = (IW+3)'(old_ff) - (IW+3)'(mprod);
               sv   = srf_pkg::sat24(tmp);
               v_in = sv[IW-1:0];
               sat_in = sat_ff | sv[IW];
               ap_raddr = (AAW+1)'(awp_ff) + (AAW+1)'(ALLPASS_DELAY);
            end
            if (st_ff == ST_AP_ADV) begin
               awp_in = (awp_ff == AAW'(ALLPASS_DELAY-1)) ? '0 : awp_ff + 1'b1;
            end
            if (st_ff == ST_DONE) begin
               // hold until the output register is free
               if (!ov_ff || rsp_tready) begin
                  if (v_ff > (IW)'((1 << (SAMPLE_WIDTH-1)) - 1)) begin
                     out_in = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
                     oflag_in = 1'b1;
                  end else if (v_ff < -(IW)'(1 << (SAMPLE_WIDTH-1))) begin
                     out_in = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
                     oflag_in = 1'b1;
                  end else begin
                     out_in = v_ff[SAMPLE_WIDTH-1:0];
                     oflag_in = sat_ff;
                  end
                  ov_in = 1'b1;
                  st_in = ST_IDLE;
               end
            end else begin
               st_in = st_ff + 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_CLEAR;
         clr_ff <= '0;
         cwp_ff <= '0;
         awp_ff <= '0;
         ov_ff  <= 1'b0;
      end else begin
         st_ff  <= st_in;
         clr_ff <= clr_in;
         cwp_ff <= cwp_in;
         awp_ff <= awp_in;
         ov_ff  <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      acc_ff   <= acc_in;
      quo_ff   <= quo_in;
      v_ff     <= v_in;
      old_ff   <= old_in;
      sat_ff   <= sat_in;
      out_ff   <= out_in;
      oflag_ff <= oflag_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = TDW'(out_ff);
   assign rsp_tuser  = oflag_ff;

   // a result may not be overwritten while it waits
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("pending result changed");
   // no sample is taken while the clearing pass runs
   a_clear: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_CLEAR |-> !req_tready)
      else $error("ready during clear");
   // the comb pointer moves once per sample
   a_cwp: assert property (@(posedge clock) disable iff (reset)
      cwp_ff != $past(cwp_ff) |-> $past(st_ff) == ST_BLEND)
      else $error("comb pointer moved out of step");
endmodule

>>> bench/tb_schroeder_reverb_filter_top.sv
// ----------------------------------------------------------------------------
// tb_schroeder_reverb_filter_top - self-checking bench for the reverb filter
// Drives samples in bursts with random gaps, stalls the result side, predicts
// every result with a bit-accurate software copy of the reverberator and
// steps through several register settings between phases.
// ----------------------------------------------------------------------------
class reverb_scoreboard;
   localparam int CDEPTH = 4096;
   localparam int ADELAY = 1968;
   localparam logic signed [63:0] AP_GAIN = 64'sd4293;

   int comb_mem [4][CDEPTH];
   int ap_mem [2][ADELAY];
   int comb_wp;
   int ap_wp;
   int delay_cfg [4];
   int fb_gain;
   int wet_pct;
   bit sat_hit;

   logic [15:0] exp_sample [$];
   bit          exp_clip [$];
   int errors;
   int checked;

   function new();
      foreach (comb_mem[i, j]) comb_mem[i][j] = 0;
      foreach (ap_mem[i, j]) ap_mem[i][j] = 0;
      comb_wp = 0;
      ap_wp = 0;
      delay_cfg = '{1102, 843, 1528, 926};
      fb_gain = 16384;
      wet_pct = 50;
      errors = 0;
      checked = 0;
   endfunction

   function void write_reg(int idx, int value);
      case (idx)
         srf_pkg::REG_DELAY_1, srf_pkg::REG_DELAY_2, srf_pkg::REG_DELAY_3,
         srf_pkg::REG_DELAY_4: delay_cfg[idx] = value & 12'hFFF;
         srf_pkg::REG_FEEDBACK: fb_gain = value & 15'h7FFF;
         srf_pkg::REG_WET: wet_pct = value & 7'h7F;
         default: ;
      endcase
   endfunction

   function longint clamp(longint v, int bits);
      longint hi;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      if (v > hi) begin
         sat_hit = 1;
         return hi;
      end
      if (v < -hi - 1) begin
         sat_hit = 1;
         return -hi - 1;
      end
      return v;
   endfunction

   // arithmetic shift is a floor divide by 2^15
   function longint scale_q15(longint g, longint v);
      longint p;
      p = g * v + 16384;
      return p >>> 15;
   endfunction

   function longint floor_div100(longint n);
      if (n >= 0) return n / 100;
      return -((-n + 99) / 100);
   endfunction

   function void note_sample(logic signed [15:0] x_in);
      longint x, y, sum, mix, w, old;
      int rd;
      int wet;
      x = x_in;
      sat_hit = 0;
      sum = 0;
      for (int k = 0; k < 4; k++) begin
         rd = (comb_wp + CDEPTH - (delay_cfg[k] % CDEPTH)) % CDEPTH;
         y = clamp(x + scale_q15(fb_gain, comb_mem[k][rd]), 24);
         comb_mem[k][comb_wp] = int'(y);
         sum += y;
      end
      comb_wp = (comb_wp + 1) % CDEPTH;
      wet = (wet_pct > 100) ? 100 : wet_pct;
      mix = clamp(floor_div100((100 - wet) * x + wet * sum + 50), 24);
      y = mix;
      for (int k = 0; k < 2; k++) begin
         old = ap_mem[k][ap_wp];
         w = clamp(y + scale_q15(AP_GAIN, old), 24);
         ap_mem[k][ap_wp] = int'(w);
         y = clamp(old - scale_q15(AP_GAIN, w), 24);
      end
      ap_wp = (ap_wp + 1) % ADELAY;
      y = clamp(y, 16);
      exp_sample.push_back(y[15:0]);
      exp_clip.push_back(sat_hit);
   endfunction

   function void check_result(logic [15:0] got_sample, logic got_clip);
      logic [15:0] es;
      bit ec;
      if (exp_sample.size() == 0) begin
         $display("%0t: unexpected result sample=%0d clipped=%0b", $time,
                  $signed(got_sample), got_clip);
         errors++;
         return;
      end
      es = exp_sample.pop_front();
      ec = exp_clip.pop_front();
      checked++;
      if (got_sample !== es) begin
         $display("%0t: sample_out expected %0d actual %0d", $time, $signed(es),
                  $signed(got_sample));
         errors++;
      end
      if (got_clip !== ec) begin
         $display("%0t: clipped expected %0b actual %0b", $time, ec, got_clip);
         errors++;
      end
   endfunction

   function int pending();
      return exp_sample.size();
   endfunction
endclass

module tb_schroeder_reverb_filter_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 100000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 0;
   logic [srf_pkg::CIDX_W-1:0] csr_index = '0;
   logic [srf_pkg::CFG_W-1:0]  csr_wdata = '0;

   reverb_scoreboard reverb_sb;
   int idle_cycles = 0;
   int sent = 0;
   int gap_left = 0;
   bit stall_mode = 0;

   schroeder_reverb_filter_top dut (.*);

   always #4 clock = ~clock;

   // sample both handshakes at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) reverb_sb.note_sample(req_tdata);
         if (rsp_tvalid && rsp_tready) reverb_sb.check_result(rsp_tdata, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // receiver stalls in phases: free running or heavy
   always @(negedge clock) begin
      if ($urandom_range(0, 99) == 0) stall_mode = ~stall_mode;
      if (!stall_mode) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) == 0);
   end

   task automatic send_sample(logic [15:0] s);
      while (gap_left > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         gap_left--;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= s;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      sent++;
      if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 40);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (reverb_sb.pending() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [srf_pkg::CIDX_W-1:0] idx, int value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[srf_pkg::CFG_W-1:0];
      @(posedge clock);
      reverb_sb.write_reg(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_all(int d1, int d2, int d3, int d4, int fb, int wet);
      write_csr(srf_pkg::REG_DELAY_1, d1);
      write_csr(srf_pkg::REG_DELAY_2, d2);
      write_csr(srf_pkg::REG_DELAY_3, d3);
      write_csr(srf_pkg::REG_DELAY_4, d4);
      write_csr(srf_pkg::REG_FEEDBACK, fb);
      write_csr(srf_pkg::REG_WET, wet);
   endtask

   // modest audio mixed with random full-range values to drive saturation
   task automatic random_run(int count, int loud_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < loud_pct) send_sample(16'($urandom()));
         else send_sample(16'($signed($urandom_range(0, 8000)) - 4000));
      end
   endtask

   initial begin
      reverb_sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: impulses, extremes, alternating bits, with reset settings
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h0000);
      send_sample(16'hFFFF);
      send_sample(16'h0001);
      send_sample(16'h5555);
      send_sample(16'hAAAA);
      for (int i = 0; i < 8; i++) send_sample(16'h7FFF);
      for (int i = 0; i < 8; i++) send_sample(16'h8000);
      drain();

      // short delays so the comb feedback shows up; loud input saturates
      set_all(1, 2, 3, 4, 32767, 100);
      random_run(300, 40);
      drain();

      // zero delay acts as full depth, wet above 100 clamps, no feedback
      set_all(0, 4095, 7, 13, 0, 127);
      random_run(250, 30);
      drain();

      // dry only
      set_all(5, 9, 11, 17, 12345, 0);
      random_run(200, 50);
      drain();

      // random settings; first delay, feedback and wet span their full ranges
      for (int ph = 0; ph < 4; ph++) begin
         set_all($urandom_range(0, 4095), $urandom_range(1, 60), $urandom_range(1, 300),
                 $urandom_range(1, 4095), $urandom_range(0, 32767), $urandom_range(0, 127));
         random_run(210, 25);
         drain();
      end

      $display("%0d samples sent, %0d results checked over the reset settings",
               sent, reverb_sb.checked);
      $display("and 7 written register settings, with sender gaps and receiver stalls");
      if (reverb_sb.errors == 0 && reverb_sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
